@@ hdl/gold_sequence_qpsk_dmrs_core_assert.svh @@
// Assertion macros for the Gold sequence QPSK reference-signal generator.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef GOLD_SEQUENCE_QPSK_DMRS_CORE_ASSERT_SVH
`define GOLD_SEQUENCE_QPSK_DMRS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSQD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsqd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsqd assertion failed");

`endif

@@ hdl/gsqd_pkg.sv @@
// Shared constants and types for the Gold sequence QPSK generator.
// No dependencies; imported by the cell, the chain and the top level.
`default_nettype none

package gsqd_pkg;

    localparam int LFSR_W = 31;
    localparam int CNT_W  = 8;
    localparam int SKIP_W = 12;
    localparam int AMP_W  = 16;

    localparam logic [CNT_W-1:0]  RUN_SYMBOLS = 8'd144;
    localparam logic [SKIP_W-1:0] SKIP_STEPS  = 12'd1600;
    localparam logic [LFSR_W-1:0] SEED_RESET  = 31'd10062025;
    localparam logic [LFSR_W-1:0] X1_INIT     = 31'd1;

    localparam logic signed [AMP_W-1:0] AMP_POS = 16'sd23170;
    localparam logic signed [AMP_W-1:0] AMP_NEG = -16'sd23170;

    // Step control broadcast along the cell row.
    typedef struct packed {
        logic load;
        logic step;
        logic dbl;
    } t_step_ctl;

    // One cell holds one bit of each LFSR.
    typedef struct packed {
        logic x1;
        logic x2;
    } t_cell_bits;

endpackage

`default_nettype wire

@@ hdl/gold_sequence_qpsk_dmrs_core.sv @@
// Gold sequence (31-bit LFSRs) QPSK reference-signal generator, top level.
// Depends on gsqd_pkg, gsqd_chain (and through it gsqd_cell).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries i_in_restart; every
//   transaction yields exactly one symbol on the output channel
//   (o_out_valid / i_out_stall): real and imaginary parts of +/-23170 in
//   Q1.15, the symbol index in the run and a last flag on symbol 143.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the 31-bit seed; it is
//   always ready and the seed is used at the next reload.
//   A plain request's symbol is registered and appears in the cycle after
//   acceptance, and requests may follow every cycle while the receiver does
//   not stall (two LFSR steps per cycle in the cell row). A reload request
//   (restart, first request after reset, or the request after the last
//   symbol) loads the row, walks the 1600-step skip at two steps per cycle,
//   then emits the symbol from ST_EMIT; the input is stalled in between.
//   Reset clears the output valid flag and forces a reload on the first
//   request; the seed returns to 10062025.
//   While the receiver stalls, the output symbol holds and the input stalls.
`default_nettype none

module gold_sequence_qpsk_dmrs_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_in_restart,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic signed [gsqd_pkg::AMP_W-1:0] o_real_part,
    output logic signed [gsqd_pkg::AMP_W-1:0] o_imag_part,
    output logic [gsqd_pkg::CNT_W-1:0]        o_symbol_index,
    output logic                              o_last,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [gsqd_pkg::LFSR_W-1:0]        i_cfg_seed
);
    import gsqd_pkg::*;

    `include "gold_sequence_qpsk_dmrs_core_assert.svh"

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [SKIP_W-1:0]         r_skip_left;
    logic [SKIP_W-1:0]         n_skip_left;
    logic                      r_loaded;
    logic [CNT_W-1:0]          r_count;
    logic [LFSR_W-1:0]         r_seed;
    logic                      r_out_valid;
    logic signed [AMP_W-1:0]   r_out_real;
    logic signed [AMP_W-1:0]   r_out_imag;
    logic [CNT_W-1:0]          r_out_index;
    logic                      r_out_last;

    logic                      w_out_free;
    logic                      w_in_acc;
    logic                      w_need_reload;
    logic                      w_emit;
    t_step_ctl                 w_ctl;
    logic [1:0]                w_gold;
    logic                      w_x1_zero;

    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall    = !((r_state == ST_RUN) && w_out_free);
    assign w_in_acc      = i_in_valid && !o_in_stall;
    assign w_need_reload = i_in_restart || !r_loaded || (r_count >= RUN_SYMBOLS);
    assign w_emit        = (w_in_acc && !w_need_reload)
                         || ((r_state == ST_EMIT) && w_out_free);

    assign w_ctl.load = w_in_acc && w_need_reload;
    assign w_ctl.step = w_emit || ((r_state == ST_SKIP) && (r_skip_left != '0));
    assign w_ctl.dbl  = w_emit || (r_skip_left != SKIP_W'(1));

    gsqd_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_seed    (r_seed),
        .o_gold    (w_gold),
        .o_x1_zero (w_x1_zero)
    );

    always_comb begin
        n_state     = r_state;
        n_skip_left = r_skip_left;
        case (r_state)
            ST_RUN: begin
                if (w_ctl.load) begin
                    n_state     = ST_SKIP;
                    n_skip_left = SKIP_STEPS;
                end
            end
            ST_SKIP: begin
                if (r_skip_left == '0) begin
                    n_state = ST_EMIT;
                end else if (r_skip_left == SKIP_W'(1)) begin
                    n_skip_left = '0;
                end else begin
                    n_skip_left = r_skip_left - SKIP_W'(2);
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_skip_left <= '0;
            r_loaded    <= 1'b0;
            r_count     <= '0;
            r_seed      <= SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_skip_left <= n_skip_left;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_seed;
            end
            if (w_ctl.load) begin
                r_loaded <= 1'b1;
                r_count  <= '0;
            end else if (w_emit) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_real  <= w_gold[0] ? AMP_NEG : AMP_POS;
            r_out_imag  <= w_gold[1] ? AMP_NEG : AMP_POS;
            r_out_index <= r_count;
            r_out_last  <= (r_count == RUN_SYMBOLS - CNT_W'(1));
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_real_part    = r_out_real;
    assign o_imag_part    = r_out_imag;
    assign o_symbol_index = r_out_index;
    assign o_last         = r_out_last;

    `GSQD_ASSERT_NOW(a_skip_stalls, i_clk, i_rst_n, r_state != ST_RUN, o_in_stall)
    `GSQD_ASSERT_NEXT(a_reload_skips, i_clk, i_rst_n, w_ctl.load, r_state == ST_SKIP)
    `GSQD_ASSERT_NOW(a_last_index, i_clk, i_rst_n, r_out_valid && r_out_last,
        r_out_index == RUN_SYMBOLS - CNT_W'(1))
    `GSQD_ASSERT_NOW(a_x1_alive, i_clk, i_rst_n, r_loaded && !w_ctl.load, !w_x1_zero)

endmodule

`default_nettype wire

@@ hdl/gsqd_cell.sv @@
// One cell of the LFSR row: holds bit k of both LFSRs.
// Depends on gsqd_pkg (t_step_ctl, t_cell_bits).
`default_nettype none

module gsqd_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  gsqd_pkg::t_step_ctl   i_ctl,
    input  gsqd_pkg::t_cell_bits  i_load_bits,
    input  gsqd_pkg::t_cell_bits  i_next1,
    input  gsqd_pkg::t_cell_bits  i_next2,
    output gsqd_pkg::t_cell_bits  o_bits
);
    import gsqd_pkg::*;

    t_cell_bits r_bits;
    t_cell_bits n_bits;

    always_comb begin
        n_bits = r_bits;
        if (i_ctl.load) begin
            n_bits = i_load_bits;
        end else if (i_ctl.step) begin
            n_bits = i_ctl.dbl ? i_next2 : i_next1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else begin
            r_bits <= n_bits;
        end
    end

    assign o_bits = r_bits;

endmodule

`default_nettype wire

@@ hdl/gsqd_chain.sv @@
// Row of LFSR cells with the feedback taps of both Gold sequence LFSRs.
// Steps one or two positions per cycle. Depends on gsqd_pkg and gsqd_cell.
`default_nettype none

module gsqd_chain (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  gsqd_pkg::t_step_ctl           i_ctl,
    input  wire [gsqd_pkg::LFSR_W-1:0]    i_seed,
    output logic [1:0]                    o_gold,
    output logic                          o_x1_zero
);
    import gsqd_pkg::*;

    `include "gold_sequence_qpsk_dmrs_core_assert.svh"

    logic [LFSR_W+1:0] w_x1_ext;
    logic [LFSR_W+1:0] w_x2_ext;
    logic [LFSR_W-1:0] w_x1;
    logic [LFSR_W-1:0] w_x2;

    // Feedback for one and for two steps ahead
    assign w_x1_ext[LFSR_W]   = w_x1[0] ^ w_x1[3];
    assign w_x1_ext[LFSR_W+1] = w_x1[1] ^ w_x1[4];
    assign w_x2_ext[LFSR_W]   = w_x2[0] ^ w_x2[1] ^ w_x2[2] ^ w_x2[3];
    assign w_x2_ext[LFSR_W+1] = w_x2[1] ^ w_x2[2] ^ w_x2[3] ^ w_x2[4];
    assign w_x1_ext[LFSR_W-1:0] = w_x1;
    assign w_x2_ext[LFSR_W-1:0] = w_x2;

    genvar k;
    generate
        for (k = 0; k < LFSR_W; k++) begin : g_cell
            t_cell_bits w_load;
            t_cell_bits w_n1;
            t_cell_bits w_n2;
            t_cell_bits w_q;

            assign w_load.x1 = X1_INIT[k];
            assign w_load.x2 = i_seed[k];
            assign w_n1.x1   = w_x1_ext[k+1];
            assign w_n1.x2   = w_x2_ext[k+1];
            assign w_n2.x1   = w_x1_ext[k+2];
            assign w_n2.x2   = w_x2_ext[k+2];

            gsqd_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (i_ctl),
                .i_load_bits (w_load),
                .i_next1     (w_n1),
                .i_next2     (w_n2),
                .o_bits      (w_q)
            );

            assign w_x1[k] = w_q.x1;
            assign w_x2[k] = w_q.x2;
        end
    endgenerate

    // Bit 0 feeds the real part, bit 1 the imaginary part
    assign o_gold    = {w_x1[1] ^ w_x2[1], w_x1[0] ^ w_x2[0]};
    assign o_x1_zero = (w_x1 == '0);

    `GSQD_ASSERT_NEXT(a_load_x1, i_clk, i_rst_n, i_ctl.load, w_x1 == X1_INIT)
    `GSQD_ASSERT_NEXT(a_load_x2, i_clk, i_rst_n, i_ctl.load, w_x2 == $past(i_seed))
    `GSQD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !i_ctl.load && !i_ctl.step,
        w_x1 == $past(w_x1) && w_x2 == $past(w_x2))

endmodule

`default_nettype wire
